FILE: rtl/masked_priority_binding_table_top_assert.svh
// Assertion macros used by the binding table sequencer.
`ifndef MASKED_PRIORITY_BINDING_TABLE_TOP_ASSERT_SVH
`define MASKED_PRIORITY_BINDING_TABLE_TOP_ASSERT_SVH

// Same-cycle implication checked at every rising clock edge outside reset.
`define MPBT_ASSERT_NOW(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication checked at every rising clock edge outside reset.
`define MPBT_ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: rtl/mpbt_pkg.sv
// Types and constants of the masked priority binding table.
`default_nettype none

package mpbt_pkg;

   localparam int MODE_W = 4;
   localparam int FLAG_W = 8;
   localparam int MOD_W  = 8;
   localparam int ITEM_W = 8;
   localparam int STAT_W = 2;

   localparam logic [FLAG_W-1:0] PROP_RESET  = 8'd7;
   localparam logic [FLAG_W-1:0] PLANE_RESET = 8'd24;

   // Command codes.
   localparam logic CMD_BIND    = 1'b0;
   localparam logic CMD_RESOLVE = 1'b1;

   // Configuration register indexes.
   localparam logic CSR_PROP  = 1'b0;
   localparam logic CSR_PLANE = 1'b1;

   // Result status codes.
   localparam logic [STAT_W-1:0] STAT_OK        = 2'd0;
   localparam logic [STAT_W-1:0] STAT_NOT_FOUND = 2'd1;
   localparam logic [STAT_W-1:0] STAT_REPLACED  = 2'd2;
   localparam logic [STAT_W-1:0] STAT_FULL      = 2'd3;

   typedef struct packed {
      logic [MODE_W-1:0] mode;
      logic [FLAG_W-1:0] flags;
      logic [MOD_W-1:0]  mods;
      logic [ITEM_W-1:0] item;
   } rule_type;

   typedef struct packed {
      logic              cmd;
      logic              tbl;
      logic [MODE_W-1:0] mode;
      logic [FLAG_W-1:0] flags;
      logic [MOD_W-1:0]  mods;
      logic [ITEM_W-1:0] item;
   } query_type;

   typedef struct packed {
      logic mode_gt;
      logic hit;
      logic same;
   } match_type;

   typedef struct packed {
      logic [ITEM_W-1:0] item;
      logic [STAT_W-1:0] status;
   } result_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_START,
      ST_SCAN,
      ST_END,
      ST_SHIFT,
      ST_INSERT,
      ST_FINISH
   } state_type;

endpackage

`default_nettype wire

FILE: rtl/mpbt_rule_ram.sv
// Rule storage for both tables with one write port and one registered read port.
`default_nettype none

module mpbt_rule_ram #(
   parameter int DEPTH = 64,
   parameter int AW    = 6
) (
   input  wire logic                 clock,
   input  wire logic                 wr_en,
   input  wire logic [AW-1:0]        wr_addr,
   input  wire mpbt_pkg::rule_type   wr_data,
   input  wire logic                 rd_en,
   input  wire logic [AW-1:0]        rd_addr,
   output mpbt_pkg::rule_type        rd_data
);

   mpbt_pkg::rule_type mem [DEPTH];
   mpbt_pkg::rule_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

FILE: rtl/mpbt_match.sv
// Rule against query comparator used by every scan step.
`default_nettype none

module mpbt_match (
   input  wire mpbt_pkg::rule_type           rule,
   input  wire mpbt_pkg::query_type          query,
   input  wire logic [mpbt_pkg::FLAG_W-1:0]  prop_mask,
   input  wire logic [mpbt_pkg::FLAG_W-1:0]  plane_mask,
   output mpbt_pkg::match_type               match
);

   logic [mpbt_pkg::FLAG_W-1:0] r_prop;
   logic [mpbt_pkg::FLAG_W-1:0] q_prop;
   logic [mpbt_pkg::FLAG_W-1:0] r_plane;
   logic [mpbt_pkg::FLAG_W-1:0] q_plane;
   logic                        prop_ok;
   logic                        plane_ok;
   logic                        mods_ok;
   logic                        mode_eq;

   // A section with no rule bits always passes; otherwise the query needs
   // bits there and the rule must cover all of them.
   always_comb begin
      r_prop   = rule.flags & prop_mask;
      q_prop   = query.flags & prop_mask;
      r_plane  = rule.flags & plane_mask;
      q_plane  = query.flags & plane_mask;
      prop_ok  = (r_prop == '0) ||
                 ((q_prop != '0) && ((rule.flags & q_prop) == q_prop));
      plane_ok = (r_plane == '0) ||
                 ((q_plane != '0) && ((rule.flags & q_plane) == q_plane));
      mods_ok  = ((rule.mods & query.mods) == rule.mods);
      mode_eq  = (rule.mode == query.mode);

      match.mode_gt = (rule.mode > query.mode);
      match.hit     = mode_eq && prop_ok && plane_ok && mods_ok;
      match.same    = match.hit && (rule.flags == query.flags) &&
                      (rule.mods == query.mods);
   end

endmodule

`default_nettype wire

FILE: rtl/mpbt_seq.sv
// Sequencer that scans, shifts and inserts rules one entry per cycle.
`default_nettype none

`include "masked_priority_binding_table_top_assert.svh"

module mpbt_seq #(
   parameter int N  = 32,
   parameter int IW = 5,
   parameter int CW = 6
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output logic                                   req_ready,
   input  wire mpbt_pkg::query_type               req_query,
   output mpbt_pkg::query_type                    query,
   input  wire mpbt_pkg::match_type               match,
   input  wire mpbt_pkg::rule_type                rd_data,
   output logic                                   rd_en,
   output logic [IW:0]                            rd_addr,
   output logic                                   wr_en,
   output logic [IW:0]                            wr_addr,
   output mpbt_pkg::rule_type                     wr_data,
   input  wire logic                              out_free,
   output logic                                   fin_valid,
   output mpbt_pkg::result_type                   fin_result
);

   mpbt_pkg::state_type  state_ff, state_in;
   mpbt_pkg::query_type  q_ff, q_in;
   mpbt_pkg::result_type res_ff, res_in;
   logic [CW-1:0]        idx_ff, idx_in;
   logic [CW-1:0]        sh_ff, sh_in;
   logic [CW-1:0]        cnt_ff [2];
   logic [CW-1:0]        cnt_in [2];
   logic [CW-1:0]        n;
   logic [CW-1:0]        idx_p1;
   logic [CW-1:0]        sh_m1;
   logic [CW-1:0]        sh_m2;
   logic [CW-1:0]        n_m1;
   mpbt_pkg::rule_type   q_rule;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= mpbt_pkg::ST_IDLE;
         cnt_ff[0] <= '0;
         cnt_ff[1] <= '0;
      end else begin
         state_ff  <= state_in;
         cnt_ff[0] <= cnt_in[0];
         cnt_ff[1] <= cnt_in[1];
      end
   end

   always_ff @(posedge clock) begin
      q_ff   <= q_in;
      res_ff <= res_in;
      idx_ff <= idx_in;
      sh_ff  <= sh_in;
   end

   always_comb begin
      n       = cnt_ff[q_ff.tbl];
      idx_p1  = idx_ff + CW'(1);
      sh_m1   = sh_ff - CW'(1);
      sh_m2   = sh_ff - CW'(2);
      n_m1    = n - CW'(1);
      q_rule  = '{mode: q_ff.mode, flags: q_ff.flags, mods: q_ff.mods, item: q_ff.item};

      state_in  = state_ff;
      q_in      = q_ff;
      res_in    = res_ff;
      idx_in    = idx_ff;
      sh_in     = sh_ff;
      cnt_in[0] = cnt_ff[0];
      cnt_in[1] = cnt_ff[1];
      req_ready = 1'b0;
      rd_en     = 1'b0;
      rd_addr   = {q_ff.tbl, idx_ff[IW-1:0]};
      wr_en     = 1'b0;
      wr_addr   = {q_ff.tbl, idx_ff[IW-1:0]};
      wr_data   = q_rule;
      fin_valid = 1'b0;

      case (state_ff)
         mpbt_pkg::ST_IDLE: begin
            // Nothing is taken while reset is held.
            req_ready = !reset;
            if (req_valid && req_ready) begin
               q_in     = req_query;
               state_in = mpbt_pkg::ST_START;
            end
         end
         mpbt_pkg::ST_START: begin
            idx_in = '0;
            if (n != '0) begin
               rd_en    = 1'b1;
               rd_addr  = {q_ff.tbl, {IW{1'b0}}};
               state_in = mpbt_pkg::ST_SCAN;
            end else begin
               state_in = mpbt_pkg::ST_END;
            end
         end
         mpbt_pkg::ST_SCAN: begin
            // The read data holds the entry at the scan index.
            if (match.mode_gt) begin
               state_in = mpbt_pkg::ST_END;
            end else if (match.hit && (q_ff.cmd == mpbt_pkg::CMD_RESOLVE)) begin
               res_in   = '{item: rd_data.item, status: mpbt_pkg::STAT_OK};
               state_in = mpbt_pkg::ST_FINISH;
            end else if (match.same && (q_ff.cmd == mpbt_pkg::CMD_BIND)) begin
               wr_en    = 1'b1;
               res_in   = '{item: '0, status: mpbt_pkg::STAT_REPLACED};
               state_in = mpbt_pkg::ST_FINISH;
            end else begin
               idx_in = idx_p1;
               if (idx_p1 < n) begin
                  rd_en   = 1'b1;
                  rd_addr = {q_ff.tbl, idx_p1[IW-1:0]};
               end else begin
                  state_in = mpbt_pkg::ST_END;
               end
            end
         end
         mpbt_pkg::ST_END: begin
            if (q_ff.cmd == mpbt_pkg::CMD_RESOLVE) begin
               res_in   = '{item: '0, status: mpbt_pkg::STAT_NOT_FOUND};
               state_in = mpbt_pkg::ST_FINISH;
            end else if (n == CW'(N)) begin
               res_in   = '{item: '0, status: mpbt_pkg::STAT_FULL};
               state_in = mpbt_pkg::ST_FINISH;
            end else if (idx_ff == n) begin
               state_in = mpbt_pkg::ST_INSERT;
            end else begin
               rd_en    = 1'b1;
               rd_addr  = {q_ff.tbl, n_m1[IW-1:0]};
               sh_in    = n;
               state_in = mpbt_pkg::ST_SHIFT;
            end
         end
         mpbt_pkg::ST_SHIFT: begin
            // Move the entry below the shift index up by one slot.
            wr_en   = 1'b1;
            wr_addr = {q_ff.tbl, sh_ff[IW-1:0]};
            wr_data = rd_data;
            sh_in   = sh_m1;
            if (sh_m1 > idx_ff) begin
               rd_en   = 1'b1;
               rd_addr = {q_ff.tbl, sh_m2[IW-1:0]};
            end else begin
               state_in = mpbt_pkg::ST_INSERT;
            end
         end
         mpbt_pkg::ST_INSERT: begin
            wr_en             = 1'b1;
            cnt_in[q_ff.tbl]  = n + CW'(1);
            res_in            = '{item: '0, status: mpbt_pkg::STAT_OK};
            state_in          = mpbt_pkg::ST_FINISH;
         end
         mpbt_pkg::ST_FINISH: begin
            fin_valid = 1'b1;
            if (out_free) begin
               state_in = mpbt_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = mpbt_pkg::ST_IDLE;
         end
      endcase
   end

   assign query      = q_ff;
   assign fin_result = res_ff;

   `MPBT_ASSERT_NOW(a_count_bound, clock, reset, 1'b1, (cnt_ff[0] <= CW'(N)) && (cnt_ff[1] <= CW'(N)), "rule count above table size")
   `MPBT_ASSERT_NOW(a_scan_range, clock, reset, state_ff == mpbt_pkg::ST_SCAN, idx_ff < n, "scan index outside the table")
   `MPBT_ASSERT_NOW(a_shift_order, clock, reset, state_ff == mpbt_pkg::ST_SHIFT, (sh_ff > idx_ff) && (n < CW'(N)), "shift past the insert point")
   `MPBT_ASSERT_NEXT(a_insert_done, clock, reset, state_ff == mpbt_pkg::ST_INSERT, state_ff == mpbt_pkg::ST_FINISH, "insert did not finish")

endmodule

`default_nettype wire

FILE: rtl/masked_priority_binding_table_top.sv
// Top level of the masked priority binding table.
//
//   Channel  Direction  Handshake              Payload
//   req_     in         req_valid / req_ready  cmd, which_table, mode, pick, modifier, item
//   rsp_     out        rsp_valid / rsp_ready  resolved_item, status
//   csr_     in         csr_valid / csr_ready  csr_index, csr_wdata
//
// One transaction is processed at a time, and the shared comparator checks one
// stored rule per cycle; a bind that inserts moves each later rule up by one,
// one per cycle. Reset is synchronous and active high; it empties both tables
// and restores the section masks, and nothing is taken while it is held.
// A result waits in an output register, so only the next final hand-off stalls on it.
`default_nettype none

module masked_priority_binding_table_top #(
   parameter int RULES_PER_TABLE = 32
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output logic                                   req_ready,
   input  wire logic                              req_cmd,
   input  wire logic                              req_which_table,
   input  wire logic [mpbt_pkg::MODE_W-1:0]       req_mode_value,
   input  wire logic [mpbt_pkg::FLAG_W-1:0]       req_pick_bits,
   input  wire logic [mpbt_pkg::MOD_W-1:0]        req_modifier_bits,
   input  wire logic [mpbt_pkg::ITEM_W-1:0]       req_item_value,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_ready,
   output logic [mpbt_pkg::ITEM_W-1:0]            rsp_resolved_item,
   output logic [mpbt_pkg::STAT_W-1:0]            rsp_status,
   input  wire logic                              csr_valid,
   output logic                                   csr_ready,
   input  wire logic                              csr_index,
   input  wire logic [mpbt_pkg::FLAG_W-1:0]       csr_wdata
);

   // Index bits for one table, and count bits that can also hold the full size.
   localparam int IW = $clog2(RULES_PER_TABLE);
   localparam int CW = $clog2(RULES_PER_TABLE + 1);

   logic [mpbt_pkg::FLAG_W-1:0] prop_mask_ff;
   logic [mpbt_pkg::FLAG_W-1:0] plane_mask_ff;
   logic                        rsp_valid_ff;
   mpbt_pkg::result_type        rsp_data_ff;

   mpbt_pkg::query_type  req_query;
   mpbt_pkg::query_type  query;
   mpbt_pkg::match_type  match;
   mpbt_pkg::rule_type   rd_data;
   mpbt_pkg::rule_type   wr_data;
   mpbt_pkg::result_type fin_result;
   logic                 rd_en;
   logic [IW:0]          rd_addr;
   logic                 wr_en;
   logic [IW:0]          wr_addr;
   logic                 fin_valid;
   logic                 out_free;

   // Section masks; writes are only expected while the block is idle.
   assign csr_ready = !reset;

   always_ff @(posedge clock) begin
      if (reset) begin
         prop_mask_ff  <= mpbt_pkg::PROP_RESET;
         plane_mask_ff <= mpbt_pkg::PLANE_RESET;
      end else if (csr_valid) begin
         case (csr_index)
            mpbt_pkg::CSR_PROP:  prop_mask_ff  <= csr_wdata;
            mpbt_pkg::CSR_PLANE: plane_mask_ff <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   assign req_query = '{cmd: req_cmd, tbl: req_which_table, mode: req_mode_value,
                        flags: req_pick_bits, mods: req_modifier_bits,
                        item: req_item_value};

   // The output register is free when empty or being drained this cycle.
   assign out_free = !rsp_valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (fin_valid && out_free) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (fin_valid && out_free) begin
         rsp_data_ff <= fin_result;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_resolved_item = rsp_data_ff.item;
   assign rsp_status        = rsp_data_ff.status;

   // Each table owns a power-of-two slice, so the table select is the top
   // address bit for any table size.
   mpbt_rule_ram #(
      .DEPTH (2 ** (IW + 1)),
      .AW    (IW + 1)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   mpbt_match u_match (
      .rule       (rd_data),
      .query      (query),
      .prop_mask  (prop_mask_ff),
      .plane_mask (plane_mask_ff),
      .match      (match)
   );

   mpbt_seq #(
      .N  (RULES_PER_TABLE),
      .IW (IW),
      .CW (CW)
   ) u_seq (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_query  (req_query),
      .query      (query),
      .match      (match),
      .rd_data    (rd_data),
      .rd_en      (rd_en),
      .rd_addr    (rd_addr),
      .wr_en      (wr_en),
      .wr_addr    (wr_addr),
      .wr_data    (wr_data),
      .out_free   (out_free),
      .fin_valid  (fin_valid),
      .fin_result (fin_result)
   );

endmodule

`default_nettype wire

FILE: tb/sv/masked_priority_binding_table_top_tb.sv
`timescale 1ns / 100ps
// Testbench of the binding table: directed and random bind and resolve traffic against shadow tables.

module masked_priority_binding_table_top_tb;

   // Table depth of the block under test; the shadow tables use the same depth.
   localparam int TABLE_DEPTH = 32;

   // Table select codes carried by req_which_table.
   localparam logic TBL_SHAPE  = 1'b0;
   localparam logic TBL_ACTION = 1'b1;

   // Random phases after the directed part, and request transactions in each.
   localparam int PHASE_COUNT = 6;
   localparam int PHASE_ITEMS = 250;

   // Every input starts at a known value; reset stays high until the main
   // sequence releases it.
   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic                          req_valid = 1'b0;
   logic                          req_ready;
   logic                          req_cmd = mpbt_pkg::CMD_BIND;
   logic                          req_which_table = TBL_SHAPE;
   logic [mpbt_pkg::MODE_W-1:0]   req_mode_value = '0;
   logic [mpbt_pkg::FLAG_W-1:0]   req_pick_bits = '0;
   logic [mpbt_pkg::MOD_W-1:0]    req_modifier_bits = '0;
   logic [mpbt_pkg::ITEM_W-1:0]   req_item_value = '0;
   logic                          rsp_valid;
   logic                          rsp_ready = 1'b0;
   logic [mpbt_pkg::ITEM_W-1:0]   rsp_resolved_item;
   logic [mpbt_pkg::STAT_W-1:0]   rsp_status;
   logic                          csr_valid = 1'b0;
   logic                          csr_ready;
   logic                          csr_index = mpbt_pkg::CSR_PROP;
   logic [mpbt_pkg::FLAG_W-1:0]   csr_wdata = '0;

   // Shadow copy of the block's state: both rule tables, their fill levels
   // and the two section masks.
   mpbt_pkg::rule_type            shadow_rules [2][TABLE_DEPTH];
   int                            shadow_count [2] = '{0, 0};
   logic [mpbt_pkg::FLAG_W-1:0]   prop_mask = mpbt_pkg::PROP_RESET;
   logic [mpbt_pkg::FLAG_W-1:0]   plane_mask = mpbt_pkg::PLANE_RESET;

   // Request transactions waiting to be driven, and the answers owed by the
   // block in the order the requests were accepted.
   mpbt_pkg::query_type           req_backlog [$];
   mpbt_pkg::result_type          table_answers [$];

   // Every bind ever queued; the random part draws on it to build lookups
   // that hit and rebinds that replace.
   mpbt_pkg::query_type           issued_binds [$];

   int                            queued_total = 0;
   int                            sent_total = 0;
   int                            mismatch_total = 0;

   // Per-side idle control: a hold count drawn after every transaction, and a
   // steady flag that switches now and then to give stretches with no idling.
   int                            req_hold = 0;
   int                            rsp_hold = 0;
   logic                          req_steady = 1'b0;
   logic                          rsp_steady = 1'b0;

   masked_priority_binding_table_top #(
      .RULES_PER_TABLE (TABLE_DEPTH)
   ) u_top (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_cmd           (req_cmd),
      .req_which_table   (req_which_table),
      .req_mode_value    (req_mode_value),
      .req_pick_bits     (req_pick_bits),
      .req_modifier_bits (req_modifier_bits),
      .req_item_value    (req_item_value),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_resolved_item (rsp_resolved_item),
      .rsp_status        (rsp_status),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   // A section passes when the rule has no bit in it, or when the query has
   // at least one bit there and every such bit is also set in the rule.
   function automatic logic section_covers(logic [mpbt_pkg::FLAG_W-1:0] rule_flags,
                                           logic [mpbt_pkg::FLAG_W-1:0] query_flags,
                                           logic [mpbt_pkg::FLAG_W-1:0] mask);
      logic [mpbt_pkg::FLAG_W-1:0] rule_sec;
      logic [mpbt_pkg::FLAG_W-1:0] query_sec;
      rule_sec  = rule_flags & mask;
      query_sec = query_flags & mask;
      if (rule_sec == '0) begin
         return 1'b1;
      end
      return (query_sec != '0) && ((rule_flags & query_sec) == query_sec);
   endfunction

   function automatic logic rule_hits(mpbt_pkg::rule_type rule,
                                      mpbt_pkg::query_type query);
      return (rule.mode == query.mode) &&
             section_covers(rule.flags, query.flags, prop_mask) &&
             section_covers(rule.flags, query.flags, plane_mask) &&
             ((rule.mods & query.mods) == rule.mods);
   endfunction

   // Applies one accepted request to the shadow tables and queues the answer
   // the block owes for it. The scan stops at the first rule whose mode lies
   // above the request's mode, so on a miss it points at the end of the mode
   // group, which is where a new rule goes.
   function automatic void apply_to_tables(mpbt_pkg::query_type query);
      mpbt_pkg::result_type answer;
      int                   fill;
      int                   pos;
      logic                 found;
      fill  = shadow_count[query.tbl];
      pos   = 0;
      found = 1'b0;
      while (!found && pos < fill && shadow_rules[query.tbl][pos].mode <= query.mode) begin
         if (rule_hits(shadow_rules[query.tbl][pos], query) &&
             (query.cmd == mpbt_pkg::CMD_RESOLVE ||
              (shadow_rules[query.tbl][pos].flags == query.flags &&
               shadow_rules[query.tbl][pos].mods == query.mods))) begin
            found = 1'b1;
         end else begin
            pos++;
         end
      end
      answer.item = '0;
      if (query.cmd == mpbt_pkg::CMD_RESOLVE) begin
         if (found) begin
            answer.item   = shadow_rules[query.tbl][pos].item;
            answer.status = mpbt_pkg::STAT_OK;
         end else begin
            answer.status = mpbt_pkg::STAT_NOT_FOUND;
         end
      end else if (found) begin
         shadow_rules[query.tbl][pos].item = query.item;
         answer.status = mpbt_pkg::STAT_REPLACED;
      end else if (fill >= TABLE_DEPTH) begin
         answer.status = mpbt_pkg::STAT_FULL;
      end else begin
         for (int j = fill; j > pos; j--) begin
            shadow_rules[query.tbl][j] = shadow_rules[query.tbl][j-1];
         end
         shadow_rules[query.tbl][pos].mode  = query.mode;
         shadow_rules[query.tbl][pos].flags = query.flags;
         shadow_rules[query.tbl][pos].mods  = query.mods;
         shadow_rules[query.tbl][pos].item  = query.item;
         shadow_count[query.tbl] = fill + 1;
         answer.status = mpbt_pkg::STAT_OK;
      end
      table_answers.push_back(answer);
   endfunction

   task automatic push_item(logic cmd, logic tbl, logic [mpbt_pkg::MODE_W-1:0] mode,
                            logic [mpbt_pkg::FLAG_W-1:0] flags,
                            logic [mpbt_pkg::MOD_W-1:0] mods,
                            logic [mpbt_pkg::ITEM_W-1:0] item);
      mpbt_pkg::query_type query;
      query = {cmd, tbl, mode, flags, mods, item};
      req_backlog.push_back(query);
      queued_total++;
      if (cmd == mpbt_pkg::CMD_BIND) begin
         issued_binds.push_back(query);
      end
   endtask

   // Writes one section mask. The shadow copy is updated at the handshake;
   // this only ever happens while the block is quiet.
   task automatic write_mask(logic index, logic [mpbt_pkg::FLAG_W-1:0] value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(posedge clock);
      while (!csr_ready) begin
         @(posedge clock);
      end
      if (index == mpbt_pkg::CSR_PROP) begin
         prop_mask = value;
      end else begin
         plane_mask = value;
      end
      csr_valid <= 1'b0;
   endtask

   // Waits until every queued request has been taken and answered. Each
   // request yields exactly one answer, so the block is idle by then; the
   // extra wait at the end is margin.
   task automatic wait_quiet();
      while (sent_total != queued_total || table_answers.size() != 0) begin
         @(posedge clock);
      end
      repeat (4) @(posedge clock);
   endtask

   // Request driver. At an accepting edge the shadow tables see the request
   // still on the ports; the next one is driven only after its idle count has
   // run out, and valid never drops while a transaction is pending.
   always @(posedge clock) begin
      mpbt_pkg::query_type next_req;
      if (reset) begin
         req_valid <= 1'b0;
         req_hold = 0;
      end else begin
         if (req_valid && req_ready) begin
            apply_to_tables({req_cmd, req_which_table, req_mode_value, req_pick_bits,
                             req_modifier_bits, req_item_value});
            sent_total++;
            if ($urandom_range(0, 29) == 0) begin
               req_steady = !req_steady;
            end
            req_hold = req_steady ? 0 : $urandom_range(0, 19);
         end
         if (!req_valid || req_ready) begin
            if (req_hold > 0) begin
               req_hold--;
               req_valid <= 1'b0;
            end else if (req_backlog.size() != 0) begin
               next_req = req_backlog.pop_front();
               req_valid         <= 1'b1;
               req_cmd           <= next_req.cmd;
               req_which_table   <= next_req.tbl;
               req_mode_value    <= next_req.mode;
               req_pick_bits     <= next_req.flags;
               req_modifier_bits <= next_req.mods;
               req_item_value    <= next_req.item;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Result monitor. Every accepted result is checked against the oldest owed
   // answer, field by field; after each one ready stays low for a drawn count.
   always @(posedge clock) begin
      mpbt_pkg::result_type owed;
      if (reset) begin
         rsp_ready <= 1'b0;
         rsp_hold = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (table_answers.size() == 0) begin
               $display("%0t: expected no result, got item %0d status %0d", $time,
                        rsp_resolved_item, rsp_status);
               mismatch_total++;
            end else begin
               owed = table_answers.pop_front();
               if (rsp_resolved_item !== owed.item) begin
                  $display("%0t: resolved_item expected %0d, got %0d", $time,
                           owed.item, rsp_resolved_item);
                  mismatch_total++;
               end
               if (rsp_status !== owed.status) begin
                  $display("%0t: status expected %0d, got %0d", $time,
                           owed.status, rsp_status);
                  mismatch_total++;
               end
            end
            if ($urandom_range(0, 29) == 0) begin
               rsp_steady = !rsp_steady;
            end
            rsp_hold = rsp_steady ? 0 : $urandom_range(0, 19);
         end
         if (rsp_hold > 0) begin
            rsp_hold--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // Main sequence: reset, a directed part, then random phases, each under
   // its own pair of section masks.
   initial begin
      mpbt_pkg::query_type         pick;
      logic [mpbt_pkg::FLAG_W-1:0] flags;
      logic [mpbt_pkg::MOD_W-1:0]  mods;
      int                          roll;

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Directed part under the reset masks (prop 0x07, plane 0x18).
      // A lookup on an empty table misses.
      push_item(mpbt_pkg::CMD_RESOLVE, TBL_SHAPE, 4'd0, 8'h00, 8'h00, 8'h00);
      // Insert, then a bind of the identical rule replaces its item.
      push_item(mpbt_pkg::CMD_BIND, TBL_SHAPE, 4'd5, 8'h01, 8'h00, 8'h11);
      push_item(mpbt_pkg::CMD_BIND, TBL_SHAPE, 4'd5, 8'h01, 8'h00, 8'hFF);
      push_item(mpbt_pkg::CMD_RESOLVE, TBL_SHAPE, 4'd5, 8'h01, 8'hFF, 8'h00);
      // The rule has a prop bit and the query none, so the rule never matches.
      push_item(mpbt_pkg::CMD_RESOLVE, TBL_SHAPE, 4'd5, 8'h00, 8'h00, 8'h00);
      // Extremes of every field; the mode 0 rule goes in front of the others.
      push_item(mpbt_pkg::CMD_BIND, TBL_SHAPE, 4'd15, 8'hFF, 8'hFF, 8'h00);
      push_item(mpbt_pkg::CMD_BIND, TBL_SHAPE, 4'd0, 8'h00, 8'h00, 8'hA5);
      push_item(mpbt_pkg::CMD_RESOLVE, TBL_SHAPE, 4'd0, 8'hFF, 8'hFF, 8'hFF);
      push_item(mpbt_pkg::CMD_RESOLVE, TBL_SHAPE, 4'd15, 8'h19, 8'hFF, 8'h00);
      // One modifier bit of the rule is missing from the query.
      push_item(mpbt_pkg::CMD_RESOLVE, TBL_SHAPE, 4'd15, 8'hFF, 8'h7F, 8'h00);
      // The action table is still empty and separate from the shape table.
      push_item(mpbt_pkg::CMD_RESOLVE, TBL_ACTION, 4'd5, 8'h01, 8'hFF, 8'h00);
      push_item(mpbt_pkg::CMD_BIND, TBL_ACTION, 4'd3, 8'h18, 8'h80, 8'h42);
      push_item(mpbt_pkg::CMD_BIND, TBL_ACTION, 4'd3, 8'h02, 8'h01, 8'h24);
      // Plane section covered; the earlier rule in the group wins.
      push_item(mpbt_pkg::CMD_RESOLVE, TBL_ACTION, 4'd3, 8'h0A, 8'h81, 8'h00);
      // Plane section empty in the query, so only the second rule can match.
      push_item(mpbt_pkg::CMD_RESOLVE, TBL_ACTION, 4'd3, 8'h02, 8'h01, 8'h00);
      // A query bit the rule does not cover in its prop section.
      push_item(mpbt_pkg::CMD_RESOLVE, TBL_ACTION, 4'd3, 8'h04, 8'h01, 8'h00);
      // Insert at the front of the table, ahead of the mode 3 group.
      push_item(mpbt_pkg::CMD_BIND, TBL_ACTION, 4'd2, 8'h00, 8'h00, 8'h01);
      push_item(mpbt_pkg::CMD_RESOLVE, TBL_ACTION, 4'd2, 8'h55, 8'hAA, 8'h00);
      wait_quiet();

      for (int phase = 0; phase < PHASE_COUNT; phase++) begin
         // Mask settings: both empty, both full, overlapping, random, the
         // reset pair, and one more random pair.
         case (phase)
            0: begin
               write_mask(mpbt_pkg::CSR_PROP, 8'h00);
               write_mask(mpbt_pkg::CSR_PLANE, 8'h00);
            end
            1: begin
               write_mask(mpbt_pkg::CSR_PROP, 8'hFF);
               write_mask(mpbt_pkg::CSR_PLANE, 8'hFF);
            end
            2: begin
               write_mask(mpbt_pkg::CSR_PROP, 8'h0F);
               write_mask(mpbt_pkg::CSR_PLANE, 8'h3C);
            end
            4: begin
               write_mask(mpbt_pkg::CSR_PROP, mpbt_pkg::PROP_RESET);
               write_mask(mpbt_pkg::CSR_PLANE, mpbt_pkg::PLANE_RESET);
            end
            default: begin
               write_mask(mpbt_pkg::CSR_PROP, 8'($urandom));
               write_mask(mpbt_pkg::CSR_PLANE, 8'($urandom));
            end
         endcase

         for (int n = 0; n < PHASE_ITEMS; n++) begin
            roll = $urandom_range(0, 99);
            // Sparse and dense flag patterns make section hits and misses
            // both likely.
            case ($urandom_range(0, 3))
               0: flags = 8'($urandom);
               1: flags = 8'(1 << $urandom_range(0, 7));
               2: flags = 8'h00;
               default: flags = 8'($urandom) & 8'($urandom);
            endcase
            case ($urandom_range(0, 3))
               0: mods = 8'($urandom);
               1: mods = 8'h00;
               2: mods = 8'hFF;
               default: mods = 8'($urandom) & 8'($urandom);
            endcase
            if (roll < 10) begin
               // New rule; once a table is full this reports it full.
               push_item(mpbt_pkg::CMD_BIND, 1'($urandom), 4'($urandom), flags, mods,
                         8'($urandom));
            end else begin
               pick = issued_binds[$urandom_range(0, issued_binds.size() - 1)];
               if (roll < 25) begin
                  // Identical rule with a new item: replaces it if it was stored, even when full.
                  push_item(mpbt_pkg::CMD_BIND, pick.tbl, pick.mode, pick.flags,
                            pick.mods, 8'($urandom));
               end else if (roll < 85) begin
                  // Lookup shaped after a known rule so that most of them hit.
                  case ($urandom_range(0, 3))
                     0: flags = pick.flags;
                     1: flags = pick.flags & 8'($urandom);
                     2: flags = pick.flags | 8'(1 << $urandom_range(0, 7));
                     default: ;
                  endcase
                  case ($urandom_range(0, 2))
                     0: mods = pick.mods;
                     1: mods = pick.mods | 8'($urandom);
                     default: ;
                  endcase
                  push_item(mpbt_pkg::CMD_RESOLVE, pick.tbl, pick.mode, flags, mods,
                            8'($urandom));
               end else begin
                  // Unrelated lookup.
                  push_item(mpbt_pkg::CMD_RESOLVE, 1'($urandom), 4'($urandom), flags,
                            mods, 8'($urandom));
               end
            end
         end
         wait_quiet();
      end

      // Everything is answered; leave room for a stray late result.
      repeat (100) @(posedge clock);
      if (mismatch_total == 0) begin
         $display("PASS masked_priority_binding_table_top");
      end else begin
         $display("FAIL masked_priority_binding_table_top");
      end
      $finish;
   end

   // Watchdog. The limit leaves room for a correct run even when every transaction
   // meets the longest gaps on both sides and the longest insert shift.
   initial begin
      #10000000;
      $display("FAIL masked_priority_binding_table_top");
      $finish;
   end

endmodule
